### hdl/bpa_pkg.sv
package bpa_pkg;

  // Sizing
  localparam int NUM_PAGE_FRAMES = 4096;
  localparam int TOP_ORDER       = 10;
  localparam int PG_W            = $clog2(NUM_PAGE_FRAMES);
  localparam int LNK_W           = PG_W + 1;
  localparam int ORD_W           = 4;
  localparam int CNT_W           = 13;
  localparam int CMD_W           = 2;
  localparam int ST_W            = 2;
  // wide enough for page + 2^order with any 4-bit order
  localparam int EW              = ((PG_W > (1 << ORD_W)) ? PG_W : (1 << ORD_W)) + 1;

  localparam int TOP_SZ  = 1 << TOP_ORDER;
  localparam int NUM_TOP = NUM_PAGE_FRAMES / TOP_SZ;
  localparam int TOP_END = NUM_TOP * TOP_SZ;

  localparam logic [LNK_W-1:0] LINK_NULL = LNK_W'(NUM_PAGE_FRAMES);
  localparam logic [LNK_W-1:0] RST_HEAD  =
    (NUM_TOP == 0) ? LINK_NULL : LNK_W'((NUM_TOP - 1) * TOP_SZ);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

  // One page descriptor
  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic             flag;
    logic [LNK_W-1:0] next;
    logic [LNK_W-1:0] prev;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DECODE,
    S_A_SRCH, S_A_SPLIT, S_A_ORD_RD, S_A_ORD_WR,
    S_F_RD, S_F_CHK, S_F_MRG, S_F_BCHK, S_F_MERGED, S_F_PUSH,
    S_R_CHK, S_R_LIST, S_R_CUR, S_R_EVAL, S_R_NEXT, S_R_SPL1, S_R_SPL2,
    S_U_RD, S_U_LAT, S_U_PV, S_U_PVW, S_U_NX, S_U_NXW, S_U_PG, S_U_PGW,
    S_P_RD, S_P_WR, S_P_HRD, S_P_HWR,
    S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LATCH, OP_DECODE,
    OP_A_SRCH, OP_A_SPLIT, OP_RD_PG, OP_A_ORD_WR,
    OP_F_RD, OP_F_CHK, OP_F_BUD, OP_F_MERGED, OP_F_PUSH,
    OP_R_CHK, OP_R_LIST, OP_R_CUR, OP_R_EVAL, OP_R_NEXT, OP_R_SPL1, OP_R_SPL2,
    OP_RD_U, OP_U_LAT, OP_U_PV, OP_U_PVW, OP_U_NX, OP_U_NXW, OP_U_PGW,
    OP_P_WR, OP_P_HRD, OP_P_HWR,
    OP_FIN
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] cmd;
    logic             ord_bad;
    logic             srch_none;
    logic             split_more;
    logic             split_bud_ok;
    logic             pg_oor;
    logic             free_bad;
    logic             mrg_try;
    logic             bud_match;
    logic             rsv_bad;
    logic             cur_null;
    logic             k_zero;
    logic             ov_none;
    logic             ov_full;
    logic             up_ok;
    logic             pv_null;
    logic             nx_null;
    logic             hd_null;
    logic             out_free;
  } sts_t;

  function automatic logic is_null(input logic [LNK_W-1:0] l);
    return l >= LINK_NULL;
  endfunction

  // Descriptor contents right after reset
  function automatic entry_t rst_entry(input logic [PG_W-1:0] idx);
    entry_t e;
    logic [LNK_W:0] ix;
    e.order = '0;
    e.flag  = 1'b0;
    e.next  = LINK_NULL;
    e.prev  = LINK_NULL;
    ix = (LNK_W+1)'(idx);
    if ((ix < (LNK_W+1)'(TOP_END)) && ((ix & (LNK_W+1)'(TOP_SZ - 1)) == '0)) begin
      e.order = ORD_W'(TOP_ORDER);
      e.flag  = 1'b1;
      e.next  = (ix == '0) ? LINK_NULL : LNK_W'(ix - (LNK_W+1)'(TOP_SZ));
      e.prev  = ((ix + (LNK_W+1)'(TOP_SZ)) < (LNK_W+1)'(TOP_END)) ?
                LNK_W'(ix + (LNK_W+1)'(TOP_SZ)) : LINK_NULL;
    end
    return e;
  endfunction

endpackage

### hdl/buddy_page_allocator_core.sv
// Buddy allocator over 4096 page frames with free lists for orders 0 to 10.
// After reset the core runs a clearing pass that writes all 4096 entries of
// the page descriptor memory; in_ready stays low until it finishes. One
// command is processed at a time. Every descriptor access goes through a
// memory with one write port and one registered read port, so each list link
// update is a read-modify-write. An allocate searches the lists, unlinks the
// block it finds and pushes the buddy of each split level before writing the
// order; a free checks the block, unlinks one free buddy per merge and ends
// with a final push. A reserve walks every free list from the top order
// down, visiting each free block, and unlinks each block it removes, or
// unlinks it and makes up to two pushes for each block it splits. The result
// is held in an output register, so out_ready may stall without losing the
// transfer; a stall holds the core in its final state until the previous
// result has gone.
module buddy_page_allocator_core import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ORD_W-1:0] in_req_order,
  input  logic [PG_W-1:0]  in_block_page,
  input  logic [CNT_W-1:0] in_page_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output logic [PG_W-1:0]  out_page_index
);

  op_t  op;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .op       (op)
  );

  bpa_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .in_cmd         (in_cmd),
    .in_req_order   (in_req_order),
    .in_block_page  (in_block_page),
    .in_page_count  (in_page_count),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_page_index (out_page_index),
    .sts            (sts)
  );

endmodule

### hdl/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/bpa_datapath.sv
module bpa_datapath import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  op_t              op,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ORD_W-1:0] in_req_order,
  input  logic [PG_W-1:0]  in_block_page,
  input  logic [CNT_W-1:0] in_page_count,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [ST_W-1:0]  out_status,
  output logic [PG_W-1:0]  out_page_index,
  output sts_t             sts
);

  // Control registers
  logic [LNK_W-1:0] heads_r   [TOP_ORDER+1];
  logic [LNK_W-1:0] heads_nxt [TOP_ORDER+1];
  logic             out_valid_r, out_valid_nxt;
  logic [PG_W-1:0]  clr_idx_r, clr_idx_nxt;

  // Working registers
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [ORD_W-1:0] rord_r, rord_nxt;
  logic [PG_W-1:0]  pg_r, pg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ORD_W-1:0] k_r, k_nxt;
  logic [PG_W-1:0]  lo_r, lo_nxt;
  logic [LNK_W-1:0] hi_r, hi_nxt;
  logic [LNK_W-1:0] cur_r, cur_nxt;
  logic [LNK_W-1:0] nxw_r, nxw_nxt;
  logic [PG_W-1:0]  u_pg_r, u_pg_nxt;
  logic [ORD_W-1:0] u_ord_r, u_ord_nxt;
  logic             u_setf_r, u_setf_nxt;
  logic [LNK_W-1:0] pv_r, pv_nxt;
  logic [LNK_W-1:0] nx_r, nx_nxt;
  logic [LNK_W-1:0] hd_r, hd_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [PG_W-1:0]  res_pg_r, res_pg_nxt;
  logic [ST_W-1:0]  ost_r, ost_nxt;
  logic [PG_W-1:0]  opg_r, opg_nxt;

  // Descriptor memory
  logic             ram_we;
  logic [PG_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  entry_t           rd_e, wr_e;

  // Derived values
  logic [ORD_W-1:0] hidx, found_k;
  logic [LNK_W-1:0] hval;
  logic             srch_none;
  logic [LNK_W-1:0] split_bud;
  logic [PG_W-1:0]  fbud;
  logic [EW-1:0]    fmask;
  logic             free_bad;
  logic [LNK_W:0]   rsum, be, up;
  logic [LNK_W-1:0] hi_c;
  logic             out_free;

  bpa_ram #(.WIDTH(ENT_W), .DEPTH(NUM_PAGE_FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e      = entry_t'(ram_rdata);
  assign ram_wdata = ENT_W'(wr_e);

  // Smallest non-empty list at or above the requested order
  always_comb begin
    srch_none = 1'b1;
    found_k   = '0;
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if ((i >= int'(rord_r)) && !is_null(heads_r[i])) begin
        found_k   = ORD_W'(i);
        srch_none = 1'b0;
      end
    end
  end

  // Single read port on the list heads
  always_comb begin
    case (op)
      OP_A_SRCH: hidx = found_k;
      OP_R_LIST: hidx = k_r;
      default:   hidx = u_ord_r;
    endcase
  end
  assign hval = heads_r[hidx];

  // Split, merge and range arithmetic
  assign split_bud = LNK_W'(pg_r) + (LNK_W'(1) << (k_r - ORD_W'(1)));
  assign fbud      = pg_r ^ (PG_W'(1) << k_r);
  assign fmask     = (EW'(1) << rd_e.order) - EW'(1);
  assign free_bad  = rd_e.flag || (rd_e.order > ORD_W'(TOP_ORDER)) ||
                     ((EW'(pg_r) & fmask) != '0) ||
                     ((EW'(pg_r) + (EW'(1) << rd_e.order)) > EW'(NUM_PAGE_FRAMES));
  assign rsum      = (LNK_W+1)'(pg_r) + (LNK_W+1)'(cnt_r);
  assign hi_c      = (rsum > (LNK_W+1)'(NUM_PAGE_FRAMES)) ? LINK_NULL : rsum[LNK_W-1:0];
  assign be        = (LNK_W+1)'(cur_r) + ((LNK_W+1)'(1) << k_r);
  assign up        = (LNK_W+1)'(cur_r) + ((LNK_W+1)'(1) << (k_r - ORD_W'(1)));
  assign out_free  = !out_valid_r || out_ready;

  // Status to the controller
  always_comb begin
    sts.clr_last     = clr_idx_r == PG_W'(NUM_PAGE_FRAMES - 1);
    sts.cmd          = cmd_r;
    sts.ord_bad      = rord_r > ORD_W'(TOP_ORDER);
    sts.srch_none    = srch_none;
    sts.split_more   = k_r > rord_r;
    sts.split_bud_ok = split_bud < LINK_NULL;
    sts.pg_oor       = LNK_W'(pg_r) >= LINK_NULL;
    sts.free_bad     = free_bad;
    sts.mrg_try      = (k_r < ORD_W'(TOP_ORDER)) && (LNK_W'(fbud) < LINK_NULL);
    sts.bud_match    = rd_e.flag && (rd_e.order == k_r);
    sts.rsv_bad      = (cnt_r == '0) || (LNK_W'(pg_r) >= LINK_NULL);
    sts.cur_null     = is_null(cur_r);
    sts.k_zero       = k_r == '0;
    sts.ov_none      = (be <= (LNK_W+1)'(lo_r)) || (cur_r >= hi_r);
    sts.ov_full      = ((cur_r >= LNK_W'(lo_r)) && (be <= (LNK_W+1)'(hi_r))) ||
                       (k_r == '0);
    sts.up_ok        = up < (LNK_W+1)'(NUM_PAGE_FRAMES);
    sts.pv_null      = is_null(pv_r);
    sts.nx_null      = is_null(nx_r);
    sts.hd_null      = is_null(hd_r);
    sts.out_free     = out_free;
  end

  // Micro-operation decode
  always_comb begin
    heads_nxt     = heads_r;
    out_valid_nxt = out_valid_r && !out_ready;
    clr_idx_nxt   = clr_idx_r;
    cmd_nxt       = cmd_r;
    rord_nxt      = rord_r;
    pg_nxt        = pg_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    nxw_nxt       = nxw_r;
    u_pg_nxt      = u_pg_r;
    u_ord_nxt     = u_ord_r;
    u_setf_nxt    = u_setf_r;
    pv_nxt        = pv_r;
    nx_nxt        = nx_r;
    hd_nxt        = hd_r;
    st_nxt        = st_r;
    res_pg_nxt    = res_pg_r;
    ost_nxt       = ost_r;
    opg_nxt       = opg_r;
    ram_we        = 1'b0;
    ram_waddr     = u_pg_r;
    ram_raddr     = u_pg_r;
    wr_e          = rd_e;

    case (op)
      OP_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        wr_e        = rst_entry(clr_idx_r);
        clr_idx_nxt = clr_idx_r + PG_W'(1);
      end
      OP_LATCH: begin
        cmd_nxt    = in_cmd;
        rord_nxt   = in_req_order;
        pg_nxt     = in_block_page;
        cnt_nxt    = in_page_count;
        st_nxt     = ST_OK;
        res_pg_nxt = '0;
      end
      OP_DECODE: begin
        if ((cmd_r != CMD_ALLOC) && (cmd_r != CMD_FREE) && (cmd_r != CMD_RESERVE)) begin
          st_nxt = ST_BAD;
        end
      end
      OP_A_SRCH: begin
        if (rord_r > ORD_W'(TOP_ORDER)) begin
          st_nxt = ST_BAD;
        end else if (srch_none) begin
          st_nxt = ST_NOMEM;
        end else begin
          k_nxt     = found_k;
          pg_nxt    = hval[PG_W-1:0];
          u_pg_nxt  = hval[PG_W-1:0];
          u_ord_nxt = found_k;
        end
      end
      OP_A_SPLIT: begin
        if (k_r > rord_r) begin
          k_nxt      = k_r - ORD_W'(1);
          u_ord_nxt  = k_r - ORD_W'(1);
          u_pg_nxt   = split_bud[PG_W-1:0];
          u_setf_nxt = 1'b1;
        end
      end
      OP_RD_PG: begin
        ram_raddr = pg_r;
      end
      OP_A_ORD_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = pg_r;
        wr_e.order = rord_r;
        res_pg_nxt = pg_r;
      end
      OP_F_RD: begin
        ram_raddr = pg_r;
        if (LNK_W'(pg_r) >= LINK_NULL) begin
          st_nxt = ST_BAD;
        end
      end
      OP_F_CHK: begin
        k_nxt = rd_e.order;
        if (free_bad) begin
          st_nxt = ST_BAD;
        end
      end
      OP_F_BUD: begin
        ram_raddr = fbud;
        u_pg_nxt  = fbud;
        u_ord_nxt = k_r;
      end
      OP_F_MERGED: begin
        if (u_pg_r < pg_r) begin
          pg_nxt = u_pg_r;
        end
        k_nxt = k_r + ORD_W'(1);
      end
      OP_F_PUSH: begin
        u_pg_nxt   = pg_r;
        u_ord_nxt  = k_r;
        u_setf_nxt = 1'b1;
      end
      OP_R_CHK: begin
        if ((cnt_r == '0) || (LNK_W'(pg_r) >= LINK_NULL)) begin
          st_nxt = ST_BAD;
        end
        lo_nxt = pg_r;
        hi_nxt = hi_c;
        k_nxt  = ORD_W'(TOP_ORDER);
      end
      OP_R_LIST: begin
        cur_nxt = hval;
      end
      OP_R_CUR: begin
        ram_raddr = cur_r[PG_W-1:0];
        if (is_null(cur_r) && (k_r != '0)) begin
          k_nxt = k_r - ORD_W'(1);
        end
      end
      OP_R_EVAL: begin
        nxw_nxt = rd_e.next;
        if (sts.ov_none) begin
          cur_nxt = rd_e.next;
        end else begin
          u_pg_nxt  = cur_r[PG_W-1:0];
          u_ord_nxt = k_r;
        end
      end
      OP_R_NEXT: begin
        cur_nxt = nxw_r;
      end
      OP_R_SPL1: begin
        u_ord_nxt  = k_r - ORD_W'(1);
        u_setf_nxt = 1'b1;
        u_pg_nxt   = up[PG_W-1:0];
      end
      // lower half goes back on the list as a free head
      OP_R_SPL2: begin
        u_pg_nxt   = cur_r[PG_W-1:0];
        u_ord_nxt  = k_r - ORD_W'(1);
        u_setf_nxt = 1'b1;
      end
      OP_RD_U: begin
        ram_raddr = u_pg_r;
      end
      // unlink: capture neighbors, fix the head if first
      OP_U_LAT: begin
        pv_nxt = rd_e.prev;
        nx_nxt = rd_e.next;
        if (is_null(rd_e.prev)) begin
          heads_nxt[u_ord_r] = rd_e.next;
        end
      end
      OP_U_PV: begin
        ram_raddr = pv_r[PG_W-1:0];
      end
      OP_U_PVW: begin
        ram_we    = 1'b1;
        ram_waddr = pv_r[PG_W-1:0];
        wr_e.next = nx_r;
      end
      OP_U_NX: begin
        ram_raddr = nx_r[PG_W-1:0];
      end
      OP_U_NXW: begin
        ram_we    = 1'b1;
        ram_waddr = nx_r[PG_W-1:0];
        wr_e.prev = pv_r;
      end
      OP_U_PGW: begin
        ram_we    = 1'b1;
        ram_waddr = u_pg_r;
        wr_e.flag = 1'b0;
        wr_e.next = LINK_NULL;
        wr_e.prev = LINK_NULL;
      end
      // push: new head points at the old one
      OP_P_WR: begin
        hd_nxt             = hval;
        ram_we             = 1'b1;
        ram_waddr          = u_pg_r;
        wr_e.order         = u_ord_r;
        wr_e.flag          = u_setf_r ? 1'b1 : rd_e.flag;
        wr_e.next          = hval;
        wr_e.prev          = LINK_NULL;
        heads_nxt[u_ord_r] = LNK_W'(u_pg_r);
      end
      OP_P_HRD: begin
        ram_raddr = hd_r[PG_W-1:0];
      end
      OP_P_HWR: begin
        ram_we    = 1'b1;
        ram_waddr = hd_r[PG_W-1:0];
        wr_e.prev = LNK_W'(u_pg_r);
      end
      OP_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ost_nxt       = st_r;
          opg_nxt       = (st_r == ST_OK) ? res_pg_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= TOP_ORDER; i++) begin
        heads_r[i] <= (i == TOP_ORDER) ? RST_HEAD : LINK_NULL;
      end
      out_valid_r <= 1'b0;
      clr_idx_r   <= '0;
    end else begin
      heads_r     <= heads_nxt;
      out_valid_r <= out_valid_nxt;
      clr_idx_r   <= clr_idx_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    rord_r   <= rord_nxt;
    pg_r     <= pg_nxt;
    cnt_r    <= cnt_nxt;
    k_r      <= k_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    cur_r    <= cur_nxt;
    nxw_r    <= nxw_nxt;
    u_pg_r   <= u_pg_nxt;
    u_ord_r  <= u_ord_nxt;
    u_setf_r <= u_setf_nxt;
    pv_r     <= pv_nxt;
    nx_r     <= nx_nxt;
    hd_r     <= hd_nxt;
    st_r     <= st_nxt;
    res_pg_r <= res_pg_nxt;
    ost_r    <= ost_nxt;
    opg_r    <= opg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = ost_r;
  assign out_page_index = opg_r;

endmodule

### hdl/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output op_t  op
);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_CLR:    if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (sts.cmd)
          CMD_ALLOC:   state_nxt = S_A_SRCH;
          CMD_FREE:    state_nxt = S_F_RD;
          CMD_RESERVE: state_nxt = S_R_CHK;
          default:     state_nxt = S_FIN;
        endcase
      end
      // allocate
      S_A_SRCH: begin
        if (sts.ord_bad || sts.srch_none) begin
          state_nxt = S_FIN;
        end else begin
          ret_nxt   = S_A_SPLIT;
          state_nxt = S_U_RD;
        end
      end
      S_A_SPLIT: begin
        if (!sts.split_more) begin
          state_nxt = S_A_ORD_RD;
        end else if (sts.split_bud_ok) begin
          ret_nxt   = S_A_SPLIT;
          state_nxt = S_P_RD;
        end
      end
      S_A_ORD_RD: state_nxt = S_A_ORD_WR;
      S_A_ORD_WR: state_nxt = S_FIN;
      // free
      S_F_RD:     state_nxt = sts.pg_oor ? S_FIN : S_F_CHK;
      S_F_CHK:    state_nxt = sts.free_bad ? S_FIN : S_F_MRG;
      S_F_MRG:    state_nxt = sts.mrg_try ? S_F_BCHK : S_F_PUSH;
      S_F_BCHK: begin
        if (sts.bud_match) begin
          ret_nxt   = S_F_MERGED;
          state_nxt = S_U_RD;
        end else begin
          state_nxt = S_F_PUSH;
        end
      end
      S_F_MERGED: state_nxt = S_F_MRG;
      S_F_PUSH: begin
        ret_nxt   = S_FIN;
        state_nxt = S_P_RD;
      end
      // reserve
      S_R_CHK:  state_nxt = sts.rsv_bad ? S_FIN : S_R_LIST;
      S_R_LIST: state_nxt = S_R_CUR;
      S_R_CUR: begin
        if (!sts.cur_null) begin
          state_nxt = S_R_EVAL;
        end else begin
          state_nxt = sts.k_zero ? S_FIN : S_R_LIST;
        end
      end
      S_R_EVAL: begin
        if (sts.ov_none) begin
          state_nxt = S_R_CUR;
        end else begin
          ret_nxt   = sts.ov_full ? S_R_NEXT : S_R_SPL1;
          state_nxt = S_U_RD;
        end
      end
      S_R_NEXT: state_nxt = S_R_CUR;
      S_R_SPL1: begin
        if (sts.up_ok) begin
          ret_nxt   = S_R_SPL2;
          state_nxt = S_P_RD;
        end else begin
          state_nxt = S_R_SPL2;
        end
      end
      S_R_SPL2: begin
        ret_nxt   = S_R_NEXT;
        state_nxt = S_P_RD;
      end
      // unlink sequence
      S_U_RD:   state_nxt = S_U_LAT;
      S_U_LAT:  state_nxt = S_U_PV;
      S_U_PV:   state_nxt = sts.pv_null ? S_U_NX : S_U_PVW;
      S_U_PVW:  state_nxt = S_U_NX;
      S_U_NX:   state_nxt = sts.nx_null ? S_U_PG : S_U_NXW;
      S_U_NXW:  state_nxt = S_U_PG;
      S_U_PG:   state_nxt = S_U_PGW;
      S_U_PGW:  state_nxt = ret_r;
      // push sequence
      S_P_RD:   state_nxt = S_P_WR;
      S_P_WR:   state_nxt = S_P_HRD;
      S_P_HRD:  state_nxt = sts.hd_null ? ret_r : S_P_HWR;
      S_P_HWR:  state_nxt = ret_r;
      S_FIN:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    case (state_r)
      S_CLR:      op = OP_CLR;
      S_IDLE: begin
        in_ready = 1'b1;
        op       = in_valid ? OP_LATCH : OP_NOP;
      end
      S_DECODE:   op = OP_DECODE;
      S_A_SRCH:   op = OP_A_SRCH;
      S_A_SPLIT:  op = OP_A_SPLIT;
      S_A_ORD_RD: op = OP_RD_PG;
      S_A_ORD_WR: op = OP_A_ORD_WR;
      S_F_RD:     op = OP_F_RD;
      S_F_CHK:    op = OP_F_CHK;
      S_F_MRG:    op = OP_F_BUD;
      S_F_MERGED: op = OP_F_MERGED;
      S_F_PUSH:   op = OP_F_PUSH;
      S_R_CHK:    op = OP_R_CHK;
      S_R_LIST:   op = OP_R_LIST;
      S_R_CUR:    op = OP_R_CUR;
      S_R_EVAL:   op = OP_R_EVAL;
      S_R_NEXT:   op = OP_R_NEXT;
      S_R_SPL1:   op = OP_R_SPL1;
      S_R_SPL2:   op = OP_R_SPL2;
      S_U_RD:     op = OP_RD_U;
      S_U_LAT:    op = OP_U_LAT;
      S_U_PV:     op = OP_U_PV;
      S_U_PVW:    op = OP_U_PVW;
      S_U_NX:     op = OP_U_NX;
      S_U_NXW:    op = OP_U_NXW;
      S_U_PG:     op = OP_RD_U;
      S_U_PGW:    op = OP_U_PGW;
      S_P_RD:     op = OP_RD_U;
      S_P_WR:     op = OP_P_WR;
      S_P_HRD:    op = OP_P_HRD;
      S_P_HWR:    op = OP_P_HWR;
      S_FIN:      op = OP_FIN;
      default:    op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

### tb/tb.sv
module tb;
  import bpa_pkg::*;

  localparam int RAND_ITEMS = 600;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [ST_W-1:0] status;
    logic [PG_W-1:0] page;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ORD_W-1:0] order;
    logic [PG_W-1:0]  page;
    logic [CNT_W-1:0] count;
    bit               typed;
    logic [ST_W-1:0]  status;
    logic [PG_W-1:0]  index;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [ORD_W-1:0] in_req_order;
  logic [PG_W-1:0]  in_block_page;
  logic [CNT_W-1:0] in_page_count;
  logic             out_valid;
  logic             out_ready;
  logic [ST_W-1:0]  out_status;
  logic [PG_W-1:0]  out_page_index;

  buddy_page_allocator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_req_order(in_req_order),
    .in_block_page(in_block_page), .in_page_count(in_page_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_page_index(out_page_index)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the page descriptors and free lists
  logic [ORD_W-1:0] shd_order [NUM_PAGE_FRAMES];
  logic             shd_free  [NUM_PAGE_FRAMES];
  int               shd_next  [NUM_PAGE_FRAMES];
  int               shd_prev  [NUM_PAGE_FRAMES];
  int               list_first[TOP_ORDER+1];

  result_t   pending_q[$];
  int        owned_pages[$];
  stim_row_t dir_rows[$];
  int        errors;
  int        idle_cycles;
  bit        in_quiet;
  bit        out_quiet;

  function automatic void list_push(int k, int pg);
    int h;
    h = list_first[k];
    shd_prev[pg] = NUM_PAGE_FRAMES;
    shd_next[pg] = h;
    if (h < NUM_PAGE_FRAMES) shd_prev[h] = pg;
    list_first[k] = pg;
  endfunction

  function automatic void list_unlink(int k, int pg);
    int pv, nx;
    pv = shd_prev[pg];
    nx = shd_next[pg];
    if (pv < NUM_PAGE_FRAMES) shd_next[pv] = nx;
    else list_first[k] = nx;
    if (nx < NUM_PAGE_FRAMES) shd_prev[nx] = pv;
    shd_prev[pg] = NUM_PAGE_FRAMES;
    shd_next[pg] = NUM_PAGE_FRAMES;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NUM_PAGE_FRAMES; i++) begin
      shd_order[i] = '0;
      shd_free[i]  = 1'b0;
      shd_next[i]  = NUM_PAGE_FRAMES;
      shd_prev[i]  = NUM_PAGE_FRAMES;
    end
    for (int k = 0; k <= TOP_ORDER; k++) list_first[k] = NUM_PAGE_FRAMES;
    for (int i = 0; i + TOP_SZ <= NUM_PAGE_FRAMES; i += TOP_SZ) begin
      shd_order[i] = ORD_W'(TOP_ORDER);
      shd_free[i]  = 1'b1;
      list_push(TOP_ORDER, i);
    end
  endfunction

  // Allocate: smallest non-empty list, pop head, split down
  function automatic result_t take_block(int ord);
    result_t r;
    int k, pg, bud;
    r.status = ST_OK;
    r.page = '0;
    if (ord > TOP_ORDER) begin
      r.status = ST_BAD;
      return r;
    end
    k = ord;
    while (k <= TOP_ORDER && list_first[k] >= NUM_PAGE_FRAMES) k++;
    if (k > TOP_ORDER) begin
      r.status = ST_NOMEM;
      return r;
    end
    pg = list_first[k];
    list_unlink(k, pg);
    shd_free[pg] = 1'b0;
    while (k > ord) begin
      k--;
      bud = pg + (1 << k);
      if (bud < NUM_PAGE_FRAMES) begin
        shd_order[bud] = ORD_W'(k);
        shd_free[bud]  = 1'b1;
        list_push(k, bud);
      end
    end
    shd_order[pg] = ORD_W'(ord);
    r.page = PG_W'(pg);
    return r;
  endfunction

  // Free: validate, merge with free buddies, push
  function automatic logic [ST_W-1:0] release_block(int pg);
    int k, bud;
    if (pg >= NUM_PAGE_FRAMES || shd_free[pg]) return ST_BAD;
    k = shd_order[pg];
    if (k > TOP_ORDER) return ST_BAD;
    if ((pg & ((1 << k) - 1)) != 0) return ST_BAD;
    if (pg + (1 << k) > NUM_PAGE_FRAMES) return ST_BAD;
    while (k < TOP_ORDER) begin
      bud = pg ^ (1 << k);
      if (bud >= NUM_PAGE_FRAMES) break;
      if (!shd_free[bud] || shd_order[bud] != ORD_W'(k)) break;
      list_unlink(k, bud);
      shd_free[bud] = 1'b0;
      if (bud < pg) pg = bud;
      k++;
    end
    shd_order[pg] = ORD_W'(k);
    shd_free[pg]  = 1'b1;
    list_push(k, pg);
    return ST_OK;
  endfunction

  // Reserve: drop or split free blocks overlapping [lo, hi)
  function automatic logic [ST_W-1:0] carve_range(int first, int count);
    int lo, hi, cur, nx, bs, be, lk, up;
    if (count == 0 || first >= NUM_PAGE_FRAMES) return ST_BAD;
    lo = first;
    hi = lo + count;
    if (hi > NUM_PAGE_FRAMES) hi = NUM_PAGE_FRAMES;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      cur = list_first[k];
      while (cur < NUM_PAGE_FRAMES) begin
        nx = shd_next[cur];
        bs = cur;
        be = bs + (1 << k);
        if (be <= lo || bs >= hi) begin
          // untouched
        end else if ((bs >= lo && be <= hi) || k == 0) begin
          list_unlink(k, cur);
          shd_free[cur] = 1'b0;
        end else begin
          lk = k - 1;
          up = cur + (1 << lk);
          list_unlink(k, cur);
          shd_order[cur] = ORD_W'(lk);
          if (up < NUM_PAGE_FRAMES) begin
            shd_order[up] = ORD_W'(lk);
            shd_free[up]  = 1'b1;
            list_push(lk, up);
          end
          list_push(lk, cur);
        end
        cur = nx;
      end
    end
    return ST_OK;
  endfunction

  function automatic result_t apply_cmd(logic [CMD_W-1:0] cmd, logic [ORD_W-1:0] ord,
                                        logic [PG_W-1:0] pg, logic [CNT_W-1:0] cnt);
    result_t r;
    r.page = '0;
    case (cmd)
      CMD_ALLOC: begin
        r = take_block(int'(ord));
        if (r.status == ST_OK) owned_pages.push_back(int'(r.page));
      end
      CMD_FREE:    r.status = release_block(int'(pg));
      CMD_RESERVE: r.status = carve_range(int'(pg), int'(cnt));
      default:     r.status = ST_BAD;
    endcase
    return r;
  endfunction

  // Mostly short gaps, a few long, with stretches of none
  function automatic int pick_gap(inout bit quiet);
    int r;
    if ($urandom_range(0, 24) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 2);
    if (r < 9) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // One input transfer; the expectation is formed when it is accepted
  task automatic send(stim_row_t row);
    int gap;
    result_t pr;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= row.cmd;
    in_req_order  <= row.order;
    in_block_page <= row.page;
    in_page_count <= row.count;
    do @(posedge clk); while (!in_ready);
    pr = apply_cmd(row.cmd, row.order, row.page, row.count);
    if (row.typed) begin
      pr.status = row.status;
      pr.page   = row.index;
    end
    pending_q.push_back(pr);
  endtask

  task automatic add_row(logic [CMD_W-1:0] cmd, int ord, int pg, int cnt,
                         bit typed = 0, logic [ST_W-1:0] st = ST_OK, int idx = 0);
    stim_row_t row;
    row.cmd = cmd;
    row.order = ORD_W'(ord);
    row.page = PG_W'(pg);
    row.count = CNT_W'(cnt);
    row.typed = typed;
    row.status = st;
    row.index = PG_W'(idx);
    dir_rows.push_back(row);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int r, j, k;
    row.typed = 0;
    row.status = ST_OK;
    row.index = '0;
    row.cmd = CMD_ALLOC;
    row.order = ORD_W'($urandom_range(0, 15));
    row.page = PG_W'($urandom);
    row.count = CNT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45 || (r < 80 && owned_pages.size() == 0)) begin
      r = $urandom_range(0, 9);
      if (r < 7) row.order = ORD_W'($urandom_range(0, 3));
      else if (r < 9) row.order = ORD_W'($urandom_range(4, TOP_ORDER));
    end else if (r < 80) begin
      row.cmd = CMD_FREE;
      j = $urandom_range(0, owned_pages.size() - 1);
      row.page = PG_W'(owned_pages[j]);
      owned_pages.delete(j);
    end else if (r < 88) begin
      // free of some random page, often aligned
      row.cmd = CMD_FREE;
      if ($urandom_range(0, 1)) begin
        k = $urandom_range(0, TOP_ORDER);
        row.page = PG_W'(($urandom_range(0, NUM_PAGE_FRAMES - 1) >> k) << k);
      end
    end else if (r < 95) begin
      row.cmd = CMD_RESERVE;
      if ($urandom_range(0, 9) != 0) row.count = CNT_W'($urandom_range(1, 32));
    end else begin
      row.cmd = CMD_UNKNOWN;
    end
    return row;
  endfunction

  // Result side: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    int gap;
    result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $error("result transfer with nothing pending: status %0d page %0d",
                 out_status, out_page_index);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errors++;
          end
          if (out_page_index !== e.page) begin
            $error("page_index: expected %0d, got %0d", e.page, out_page_index);
            errors++;
          end
        end
      end
      gap = pick_gap(out_quiet);
      out_ready <= (gap == 0);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int waited;
    errors = 0;
    idle_cycles = 0;
    in_quiet = 0;
    out_quiet = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_ALLOC;
    in_req_order  <= '0;
    in_block_page <= '0;
    in_page_count <= '0;
    shadow_reset();

    // Directed rows: typed expectations only where obvious from reset state
    add_row(CMD_ALLOC, TOP_ORDER, 0, 0, 1, ST_OK, TOP_END - TOP_SZ);
    add_row(CMD_ALLOC, 11, 0, 0, 1, ST_BAD, 0);
    add_row(CMD_ALLOC, 15, 0, 0, 1, ST_BAD, 0);
    add_row(CMD_UNKNOWN, 0, 4095, 8191, 1, ST_BAD, 0);
    add_row(CMD_FREE, 0, TOP_END - TOP_SZ, 0, 1, ST_OK, 0);
    add_row(CMD_FREE, 0, TOP_END - TOP_SZ, 0, 1, ST_BAD, 0);
    add_row(CMD_RESERVE, 0, 7, 0, 1, ST_BAD, 0);
    add_row(CMD_ALLOC, 0, 0, 0);
    add_row(CMD_FREE, 0, 3073, 0);
    add_row(CMD_FREE, 0, 3072, 0);
    for (int i = 0; i < NUM_TOP; i++) add_row(CMD_ALLOC, TOP_ORDER, 0, 0);
    add_row(CMD_ALLOC, 0, 0, 0, 1, ST_NOMEM, 0);
    for (int i = 0; i < NUM_TOP; i++) add_row(CMD_FREE, 0, i * TOP_SZ, 0);
    add_row(CMD_FREE, 0, 5, 0);
    add_row(CMD_FREE, 0, 4095, 0);
    add_row(CMD_RESERVE, 0, 4095, 8191);
    add_row(CMD_RESERVE, 0, 0, 1);
    add_row(CMD_RESERVE, 0, 100, 4096);
    add_row(CMD_ALLOC, 2, 0, 0);
    add_row(CMD_ALLOC, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send(dir_rows[i]);
    owned_pages.delete();
    for (int i = 0; i < RAND_ITEMS; i++) send(random_row());
    in_valid <= 1'b0;

    // Drain: watchdog covers a hung block
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_datapath.sv
hdl/bpa_ctrl.sv
hdl/buddy_page_allocator_core.sv
tb/tb.sv
